@@ hdl/llnt_pkg.sv @@
// ----------------------------------------------------------------------------
// llnt_pkg
// Shared types and constants of the least loaded node table.
// ----------------------------------------------------------------------------
package llnt_pkg;

  localparam int SLOTS_DEF = 32;

  localparam int TYPE_W = 16;
  localparam int ID_W   = 16;
  localparam int LOAD_W = 32;
  localparam int CMD_W  = 3;

  localparam int IN_DATA_W  = 104;  // 99 bits of fields, zero padded to bytes
  localparam int OUT_DATA_W = 56;   // 51 bits of fields, zero padded to bytes

  typedef enum logic [CMD_W-1:0] {
    CMD_REPORT = 3'd0,
    CMD_CLOSE  = 3'd1,
    CMD_CHOOSE = 3'd2,
    CMD_CHECK  = 3'd3,
    CMD_GET    = 3'd4
  } cmd_t;

  // one table row as stored in the memory
  typedef struct packed {
    logic                     valid;
    logic [TYPE_W-1:0]        ntype;
    logic [ID_W-1:0]          nid;
    logic signed [LOAD_W-1:0] nload;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;  // latch the accepted item, clear scan results
    logic rd_en;      // read the row at the scan address
    logic clear_wr;   // write an empty row at the scan address
    logic commit;     // apply the table update and load the result register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
  } dp_sts_t;

endpackage

@@ hdl/llnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// llnt_ctrl
// Sequencer: clearing pass after reset, then per item a scan over all rows,
// a drain state for the read pipeline and a commit.
// ----------------------------------------------------------------------------
module llnt_ctrl #(
  parameter int SLOTS = llnt_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  llnt_pkg::dp_sts_t          sts,
  output llnt_pkg::ctl_cmd_t         cmd,
  output logic [$clog2(SLOTS)-1:0]   addr
);
  import llnt_pkg::*;

  localparam int AW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          cnt_last;

  assign cnt_last  = (cnt_r == AW'(SLOTS - 1));
  assign in_tready = (state_r == ST_IDLE);
  assign addr      = cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cnt_nxt      = cnt_r + AW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      // last row is still in the read register
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/llnt_dpath.sv @@
// ----------------------------------------------------------------------------
// llnt_dpath
// Node table memory, scan accumulators (match, free slot, minimum, sum),
// table update and result register.
// ----------------------------------------------------------------------------
module llnt_dpath #(
  parameter int SLOTS = llnt_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  llnt_pkg::ctl_cmd_t                 cmd,
  input  logic [$clog2(SLOTS)-1:0]           addr,
  output llnt_pkg::dp_sts_t                  sts,
  input  logic [llnt_pkg::CMD_W-1:0]         in_cmd,
  input  logic [llnt_pkg::TYPE_W-1:0]        in_node_type,
  input  logic [llnt_pkg::ID_W-1:0]          in_node_id,
  input  logic signed [llnt_pkg::LOAD_W-1:0] in_load,
  input  logic signed [llnt_pkg::LOAD_W-1:0] in_limit,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [llnt_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import llnt_pkg::*;

  localparam int AW    = $clog2(SLOTS);
  localparam int SUM_W = LOAD_W + AW + 1;

  entry_t mem [SLOTS];

  // latched item
  cmd_t                     cmd_r;
  logic [TYPE_W-1:0]        type_r;
  logic [ID_W-1:0]          id_r;
  logic signed [LOAD_W-1:0] load_r;
  logic signed [LOAD_W-1:0] limit_r;

  // read pipeline
  entry_t        rdata_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  // scan results
  logic                     hit_r;
  logic [AW-1:0]            hit_idx_r;
  logic signed [LOAD_W-1:0] hit_load_r;
  logic                     free_r;
  logic [AW-1:0]            free_idx_r;
  logic                     best_vld_r;
  logic [ID_W-1:0]          best_id_r;
  logic signed [LOAD_W-1:0] best_load_r;
  logic signed [SUM_W-1:0]  sum_r;

  // result register
  logic                     out_vld_r;
  logic                     found_r;
  logic [ID_W-1:0]          chosen_id_r;
  logic signed [LOAD_W-1:0] load_value_r;
  logic                     over_limit_r;
  logic                     table_full_r;

  logic                     type_match;
  logic                     id_match;
  logic                     wr_en;
  logic [AW-1:0]            wr_idx;
  entry_t                   wr_data;

  logic                     found_c;
  logic [ID_W-1:0]          chosen_id_c;
  logic signed [LOAD_W-1:0] load_value_c;
  logic                     over_limit_c;
  logic                     table_full_c;

  assign type_match = rdata_r.valid && (rdata_r.ntype == type_r);
  assign id_match   = type_match && (rdata_r.nid == id_r);

  assign sts.out_free = !out_vld_r || out_tready;

  // table update and result selection at commit
  always_comb begin
    wr_en        = 1'b0;
    wr_idx       = hit_r ? hit_idx_r : free_idx_r;
    wr_data      = '{valid: 1'b1, ntype: type_r, nid: id_r, nload: load_r};
    found_c      = 1'b0;
    chosen_id_c  = '0;
    load_value_c = '0;
    over_limit_c = 1'b0;
    table_full_c = 1'b0;
    case (cmd_r)
      CMD_REPORT: begin
        wr_en        = hit_r || free_r;
        table_full_c = !hit_r && !free_r;
      end
      CMD_CLOSE: begin
        wr_en         = hit_r;
        wr_data.valid = 1'b0;
      end
      CMD_CHOOSE: begin
        found_c      = best_vld_r;
        chosen_id_c  = best_vld_r ? best_id_r : '0;
        load_value_c = best_vld_r ? best_load_r : '0;
      end
      CMD_CHECK: begin
        over_limit_c = (sum_r > SUM_W'(limit_r));
      end
      CMD_GET: begin
        found_c      = hit_r;
        chosen_id_c  = hit_r ? id_r : '0;
        load_value_c = hit_r ? hit_load_r : '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[addr] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
    rd_idx_r <= addr;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r   <= cmd_t'(in_cmd);
      type_r  <= in_node_type;
      id_r    <= in_node_id;
      load_r  <= in_load;
      limit_r <= in_limit;
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      best_vld_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load_item) begin
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
        best_vld_r <= 1'b0;
        sum_r      <= '0;
      end else if (rd_vld_r) begin
        if (id_match) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= rd_idx_r;
          hit_load_r <= rdata_r.nload;
        end
        // lowest empty row wins
        if (!rdata_r.valid && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
        // strict compare keeps the lowest row on ties
        if (type_match && (!best_vld_r || (rdata_r.nload < best_load_r))) begin
          best_vld_r  <= 1'b1;
          best_id_r   <= rdata_r.nid;
          best_load_r <= rdata_r.nload;
        end
        if (type_match) begin
          sum_r <= sum_r + SUM_W'(rdata_r.nload);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r      <= found_c;
      chosen_id_r  <= chosen_id_c;
      load_value_r <= load_value_c;
      over_limit_r <= over_limit_c;
      table_full_r <= table_full_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, table_full_r, over_limit_r, load_value_r, chosen_id_r, found_r};

endmodule

@@ hdl/least_loaded_node_table.sv @@
// After an input transfer the controller scans all rows, drains the read register
//   and commits once the result register is free; only then is a new item taken.
//   The scan reads one row per cycle through the table memory's read port.
// reset: synchronous active low; afterwards a clearing pass empties the table,
//   with in_tready low until it is done
// ----------------------------------------------------------------------------
// least_loaded_node_table
// Node table with report, close, least-loaded choose, overload check and get.
// ----------------------------------------------------------------------------
module least_loaded_node_table #(
  parameter int SLOTS = llnt_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd[2:0], node_type[18:3], node_id[34:19], load[66:35], limit[98:67]
  input  logic [llnt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found[0], chosen_id[16:1], load_value[48:17], over_limit[49], table_full[50]
  output logic [llnt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import llnt_pkg::*;

  localparam int AW = $clog2(SLOTS);

  ctl_cmd_t      ctl_cmd;
  dp_sts_t       dp_sts;
  logic [AW-1:0] scan_addr;

  llnt_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (ctl_cmd),
    .addr      (scan_addr)
  );

  llnt_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (ctl_cmd),
    .addr         (scan_addr),
    .sts          (dp_sts),
    .in_cmd       (in_tdata[2:0]),
    .in_node_type (in_tdata[18:3]),
    .in_node_id   (in_tdata[34:19]),
    .in_load      (in_tdata[66:35]),
    .in_limit     (in_tdata[98:67]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  // table is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during clearing pass");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in work");

  // a commit never overwrites a result that has not been taken
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten before transfer");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |=> out_tvalid)
    else $error("commit did not present a result");

endmodule

@@ verif/tb_least_loaded_node_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_loaded_node_table
// Self-checking bench for the node table: a behavioral copy of the table
// predicts every result. Directed tests cover the empty table, load and sum
// extremes, ties, unused codes and a full table. Random traffic follows,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_least_loaded_node_table;
  import llnt_pkg::*;

  localparam int SLOTS            = SLOTS_DEF;
  localparam int SUM_W            = 40;
  localparam int MAX_GAP          = 13;
  localparam int RANDOM_ITEMS     = 520;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int FIRST_UNUSED_CMD = int'(CMD_GET) + 1;
  localparam int LAST_CMD_CODE    = (1 << CMD_W) - 1;
  localparam logic [TYPE_W-1:0] FULL_TYPE = 16'h1234;
  localparam logic [LOAD_W-1:0] LOAD_MIN  = 32'h8000_0000;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = 32'h7FFF_FFFF;
  localparam logic [LOAD_W-1:0] LOAD_NEG1 = 32'hFFFF_FFFF;

  // packed with the last field (cmd) in the lowest bits
  typedef struct packed {
    logic [LOAD_W-1:0] limit;
    logic [LOAD_W-1:0] load;
    logic [ID_W-1:0]   node_id;
    logic [TYPE_W-1:0] node_type;
    logic [CMD_W-1:0]  cmd;
  } node_cmd_t;

  typedef struct packed {
    logic              table_full;
    logic              over_limit;
    logic [LOAD_W-1:0] load_value;
    logic [ID_W-1:0]   chosen_id;
    logic              found;
  } node_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predicted table contents, empty after reset
  logic                     tbl_valid [SLOTS] = '{default: 1'b0};
  logic [TYPE_W-1:0]        tbl_type  [SLOTS];
  logic [ID_W-1:0]          tbl_id    [SLOTS];
  logic signed [LOAD_W-1:0] tbl_load  [SLOTS];

  node_result_t pending_results [$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           no_gaps     = 1'b0;

  least_loaded_node_table #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic node_result_t predict_node_result(input node_cmd_t item);
    node_result_t             res;
    int                       slot;
    int                       i;
    bit                       have;
    logic signed [LOAD_W-1:0] best;
    logic signed [SUM_W-1:0]  type_sum;
    res      = '0;
    slot     = -1;
    have     = 1'b0;
    best     = '0;
    type_sum = '0;
    for (i = 0; i < SLOTS; i++) begin
      if (slot < 0 && tbl_valid[i] && tbl_type[i] == item.node_type &&
          tbl_id[i] == item.node_id) begin
        slot = i;
      end
    end
    case (item.cmd)
      CMD_REPORT: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (slot < 0) begin
          res.table_full = 1'b1;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_type[slot]  = item.node_type;
          tbl_id[slot]    = item.node_id;
          tbl_load[slot]  = item.load;
        end
      end
      CMD_CLOSE: begin
        if (slot >= 0) tbl_valid[slot] = 1'b0;
      end
      CMD_CHOOSE: begin
        // strict compare keeps the lowest slot on ties
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_type[i] == item.node_type &&
              (!have || tbl_load[i] < best)) begin
            have          = 1'b1;
            best          = tbl_load[i];
            res.chosen_id = tbl_id[i];
          end
        end
        res.found      = have;
        res.load_value = best;
      end
      CMD_CHECK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_type[i] == item.node_type) begin
            type_sum = type_sum + tbl_load[i];
          end
        end
        res.over_limit = (type_sum > $signed(item.limit));
      end
      CMD_GET: begin
        if (slot >= 0) begin
          res.found      = 1'b1;
          res.chosen_id  = item.node_id;
          res.load_value = tbl_load[slot];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic node_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
                                         input logic [TYPE_W-1:0] node_type,
                                         input logic [ID_W-1:0] node_id,
                                         input logic [LOAD_W-1:0] load,
                                         input logic [LOAD_W-1:0] limit);
    node_cmd_t item;
    item.cmd       = cmd;
    item.node_type = node_type;
    item.node_id   = node_id;
    item.load      = load;
    item.limit     = limit;
    return item;
  endfunction

  // small values make ties and sums near the limit likely
  function automatic logic [LOAD_W-1:0] random_load();
    logic [LOAD_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = LOAD_W'($urandom_range(0, 8)) - 32'd4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = LOAD_MIN;
          1: v = LOAD_MAX;
          2: v = LOAD_NEG1;
          default: v = '0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic node_cmd_t random_node_cmd(input int unsigned report_pct);
    node_cmd_t   item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: item.node_type = 16'h0000;
      1: item.node_type = 16'hFFFF;
      2: item.node_type = 16'h00FF;
      default: item.node_type = 16'hFF00;
    endcase
    item.node_id = ID_W'(16'h1111 * $urandom_range(0, 15));
    item.load    = random_load();
    item.limit   = random_load();
    if (pick < report_pct) begin
      item.cmd = CMD_REPORT;
    end else if (pick >= 96) begin
      item.cmd = CMD_W'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
    end else begin
      case (pick % 4)
        0: item.cmd = CMD_CLOSE;
        1: item.cmd = CMD_CHOOSE;
        2: item.cmd = CMD_CHECK;
        default: item.cmd = CMD_GET;
      endcase
    end
    // lookups of nodes that are most likely absent
    if (item.cmd != CMD_REPORT && $urandom_range(0, 9) == 0) begin
      item.node_type = TYPE_W'($urandom);
      item.node_id   = ID_W'($urandom);
    end
    return item;
  endfunction

  task automatic send_node_cmd(input node_cmd_t item);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - $bits(node_cmd_t)){1'b0}}, item};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_node_result(item));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: a fresh random stall, possibly none, before every transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    if (error_count < 10) begin
      $display("mismatch on %s at cycle %0d: expected %h, got %h", what,
               cycle_count, want, got);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    node_result_t got;
    node_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(node_result_t)-1:0];
      if (pending_results.size() == 0) begin
        flag_error("unexpected result", '0, 64'(got));
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          flag_error("found", 64'(want.found), 64'(got.found));
        end
        if (got.chosen_id !== want.chosen_id) begin
          flag_error("chosen_id", 64'(want.chosen_id), 64'(got.chosen_id));
        end
        if (got.load_value !== want.load_value) begin
          flag_error("load_value", 64'(want.load_value), 64'(got.load_value));
        end
        if (got.over_limit !== want.over_limit) begin
          flag_error("over_limit", 64'(want.over_limit), 64'(got.over_limit));
        end
        if (got.table_full !== want.table_full) begin
          flag_error("table_full", 64'(want.table_full), 64'(got.table_full));
        end
      end
    end
  end

  task automatic test_empty_table();
    send_node_cmd(make_cmd(CMD_CHOOSE, 16'h0000, 16'h0000, '0, '0));
    send_node_cmd(make_cmd(CMD_CHECK, 16'h0000, 16'h0000, '0, LOAD_NEG1));
    send_node_cmd(make_cmd(CMD_CHECK, 16'hFFFF, 16'h0000, '0, '0));
    send_node_cmd(make_cmd(CMD_GET, 16'hFFFF, 16'hFFFF, '0, '0));
    send_node_cmd(make_cmd(CMD_CLOSE, 16'h0000, 16'h0000, '0, '0));
  endtask

  task automatic test_load_extremes();
    send_node_cmd(make_cmd(CMD_REPORT, 16'hFFFF, 16'hFFFF, LOAD_MAX, LOAD_MAX));
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0000, 16'h0000, LOAD_MIN, LOAD_MIN));
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0000, 16'h0001, LOAD_NEG1, '0));
    send_node_cmd(make_cmd(CMD_CHOOSE, 16'h0000, 16'hFFFF, '0, '0));
    send_node_cmd(make_cmd(CMD_GET, 16'hFFFF, 16'hFFFF, '0, '0));
    // overwrite, then -1 is the smallest real load
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0000, 16'h0000, 32'd5, '0));
    send_node_cmd(make_cmd(CMD_CHOOSE, 16'h0000, 16'h0000, '0, '0));
    // tie goes to the lower slot
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0000, 16'h0002, LOAD_NEG1, '0));
    send_node_cmd(make_cmd(CMD_CHOOSE, 16'h0000, 16'h0000, '0, '0));
    send_node_cmd(make_cmd(CMD_CLOSE, 16'h0000, 16'h0001, '0, '0));
    send_node_cmd(make_cmd(CMD_GET, 16'h0000, 16'h0001, '0, '0));
  endtask

  task automatic test_sum_width();
    // sums that leave the 32-bit range
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0007, 16'h0000, LOAD_MAX, '0));
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0007, 16'h0001, LOAD_MAX, '0));
    send_node_cmd(make_cmd(CMD_CHECK, 16'h0007, 16'h0000, '0, LOAD_MAX));
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0008, 16'h0000, LOAD_MIN, '0));
    send_node_cmd(make_cmd(CMD_REPORT, 16'h0008, 16'h0001, LOAD_MIN, '0));
    send_node_cmd(make_cmd(CMD_CHECK, 16'h0008, 16'h0000, '0, LOAD_MIN));
  endtask

  task automatic test_unused_cmds();
    int code;
    for (code = FIRST_UNUSED_CMD; code <= LAST_CMD_CODE; code++) begin
      send_node_cmd(make_cmd(CMD_W'(code), 16'h0000, 16'h0000, $urandom, $urandom));
    end
  endtask

  task automatic test_table_full();
    int free_slots;
    int i;
    int next_id;
    free_slots = 0;
    next_id    = 0;
    for (i = 0; i < SLOTS; i++) if (!tbl_valid[i]) free_slots++;
    repeat (free_slots) begin
      send_node_cmd(make_cmd(CMD_REPORT, FULL_TYPE, ID_W'(next_id), random_load(), '0));
      next_id++;
    end
    send_node_cmd(make_cmd(CMD_REPORT, FULL_TYPE, 16'h0100, 32'd1, '0));
    send_node_cmd(make_cmd(CMD_REPORT, FULL_TYPE, 16'h0000, LOAD_MIN, '0));
    send_node_cmd(make_cmd(CMD_CHOOSE, FULL_TYPE, 16'h0000, '0, '0));
    send_node_cmd(make_cmd(CMD_CHECK, FULL_TYPE, 16'h0000, '0, '0));
    send_node_cmd(make_cmd(CMD_CLOSE, FULL_TYPE, 16'h0000, '0, '0));
    send_node_cmd(make_cmd(CMD_REPORT, FULL_TYPE, 16'h0100, 32'd1, '0));
    send_node_cmd(make_cmd(CMD_GET, FULL_TYPE, 16'h0100, '0, '0));
    send_node_cmd(make_cmd(CMD_CLOSE, FULL_TYPE, 16'h0100, '0, '0));
    for (i = 1; i < next_id; i++) begin
      send_node_cmd(make_cmd(CMD_CLOSE, FULL_TYPE, ID_W'(i), '0, '0));
    end
  endtask

  task automatic test_random_traffic();
    int          sent;
    int unsigned report_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // each block leans toward filling or emptying the table
      case ($urandom_range(0, 2))
        0: report_pct = 20;
        1: report_pct = 50;
        default: report_pct = 80;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (40) begin
        send_node_cmd(random_node_cmd(report_pct));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_load_extremes();
    test_sum_width();
    test_unused_cmds();
    wait_results_drained();
    test_table_full();
    test_random_traffic();
    wait_results_drained();
    repeat (SLOTS + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/llnt_pkg.sv
hdl/llnt_ctrl.sv
hdl/llnt_dpath.sv
hdl/least_loaded_node_table.sv
verif/tb_least_loaded_node_table.sv
